### rtl/bda_pkg.sv
// Package for the binary to decimal ASCII converter.
// Holds the shared constants and the digit-count function; no dependencies.
package bda_pkg;

  localparam int BDA_NUMBER_BITS = 32;
  localparam int BDA_QUEUE_DEPTH = 2;
  localparam logic [1:0] BDA_ASCII_ZONE = 2'b11;

  function automatic int bda_digits(input int nbits);
    return ((nbits * 1233) >>> 12) + 1;
  endfunction

endpackage

### rtl/bda_queue.sv
// Front end of the converter: accepts items and holds them in a short queue.
// Depends on bda_pkg.
module bda_queue
  import bda_pkg::*;
#(
  parameter int NUMBER_BITS = BDA_NUMBER_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic [NUMBER_BITS-1:0] push_number,
  output logic                   full,
  output logic                   q_valid,
  output logic [NUMBER_BITS-1:0] q_number,
  input  logic                   pop
);

  localparam int PTR_W = (BDA_QUEUE_DEPTH > 1) ? $clog2(BDA_QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(BDA_QUEUE_DEPTH + 1);

  logic [NUMBER_BITS-1:0] mem_r [BDA_QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(BDA_QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_number = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(BDA_QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_number;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(BDA_QUEUE_DEPTH))
    else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !pop) |=> !(cnt_r == '0))
    else $error("full queue lost its items");

endmodule

### rtl/bda_conv.sv
// Back end of the converter: shift-and-add-3 to BCD, then emits ASCII digits.
// Depends on bda_pkg.
module bda_conv
  import bda_pkg::*;
#(
  parameter int NUMBER_BITS = BDA_NUMBER_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  logic [NUMBER_BITS-1:0] q_number,
  output logic                   pop,
  output logic                   out_valid,
  output logic [5:0]             out_digit_char,
  output logic                   out_last
);

  localparam int NUM_DIGITS = bda_digits(NUMBER_BITS);
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int BIT_CNT_W  = $clog2(NUMBER_BITS + 1);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SKIP = 4'b0100,
    S_EMIT = 4'b1000
  } conv_state_t;

  conv_state_t            state_r, state_nxt;
  logic [NUMBER_BITS-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [BCD_W-1:0]       bcd_adj;
  logic [BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0]   dig_cnt_r, dig_cnt_nxt;
  logic [3:0]             top_digit;
  logic                   out_valid_r, out_valid_nxt;
  logic [5:0]             out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  assign top_digit      = bcd_r[BCD_W-1 -: 4];
  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;
  assign pop            = (state_r == S_IDLE) && q_valid;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          bin_nxt     = q_number;
          bcd_nxt     = '0;
          bit_cnt_nxt = BIT_CNT_W'(NUMBER_BITS);
          state_nxt   = S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt     = {bcd_adj[BCD_W-2:0], bin_r[NUMBER_BITS-1]};
        bin_nxt     = {bin_r[NUMBER_BITS-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - BIT_CNT_W'(1);
        if (bit_cnt_r == BIT_CNT_W'(1)) begin
          dig_cnt_nxt = DIG_CNT_W'(NUM_DIGITS);
          state_nxt   = S_SKIP;
        end
      end
      S_SKIP: begin
        if (top_digit == 4'd0 && dig_cnt_r != DIG_CNT_W'(1)) begin
          bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
          dig_cnt_nxt = dig_cnt_r - DIG_CNT_W'(1);
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = {BDA_ASCII_ZONE, top_digit};
        out_last_nxt  = (dig_cnt_r == DIG_CNT_W'(1));
        bcd_nxt       = {bcd_r[BCD_W-5:0], 4'd0};
        dig_cnt_nxt   = dig_cnt_r - DIG_CNT_W'(1);
        if (dig_cnt_r == DIG_CNT_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_valid_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_EMIT))
    else $error("digit strobe outside emit");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> !out_valid_r)
    else $error("digit follows last digit directly");

  a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CONV) |-> (bit_cnt_r != '0))
    else $error("bit counter empty during conversion");

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT || state_r == S_SKIP) |-> (dig_cnt_r != '0))
    else $error("digit counter empty during output");

endmodule

### rtl/binary_to_decimal_ascii.sv
// Top level of the binary to decimal ASCII converter.
// Instantiates bda_queue (front end) and bda_conv (back end); uses bda_pkg.
//
//   channel  ports                                  handshake
//   input    start, busy, in_number                 taken when start && !busy
//   result   out_valid, out_digit_char, out_last    one-cycle strobe, no stall
//
// Each number goes through the back end in order: it is taken from the queue,
// runs NUMBER_BITS shift-and-add-3 steps, drops its leading zeros from the D
// digit slots (10 for 32 bits), keeping at least one digit, and emits one digit
// per strobe. The two-entry queue takes new numbers while the back end works;
// busy is high while it is full.
// Synchronous active-low reset empties the queue and drops any conversion.
module binary_to_decimal_ascii
  import bda_pkg::*;
#(
  parameter int NUMBER_BITS = BDA_NUMBER_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [NUMBER_BITS-1:0] in_number,
  output logic                   out_valid,
  output logic [5:0]             out_digit_char,
  output logic                   out_last
);

  logic                   q_valid;
  logic [NUMBER_BITS-1:0] q_number;
  logic                   q_pop;
  logic                   q_full;

  assign busy = q_full;

  bda_queue #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (start && !q_full),
    .push_number (in_number),
    .full        (q_full),
    .q_valid     (q_valid),
    .q_number    (q_number),
    .pop         (q_pop)
  );

  bda_conv #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_conv (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_number       (q_number),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last       (out_last)
  );

endmodule

### test/binary_to_decimal_ascii_check.sv
// Checker for the binary to decimal ASCII converter: watches both channels,
// predicts the digit items of every accepted number and compares them.
// Depends on bda_pkg for the number width.
module binary_to_decimal_ascii_check
  import bda_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic [BDA_NUMBER_BITS-1:0] in_number,
  input  logic                       out_valid,
  input  logic [5:0]                 out_digit_char,
  input  logic                       out_last,
  output int                         mismatch_count,
  output int                         digits_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [5:0] ASCII_ZERO = 6'd48;
  localparam int         RADIX      = 10;

  typedef struct packed {
    logic [5:0] digit_char;
    logic       last;
  } digit_item_t;

  digit_item_t digit_queue[$];
  int          errors = 0;

  assign mismatch_count = errors;
  assign digits_pending = digit_queue.size();

  task automatic queue_decimal_digits(input logic [BDA_NUMBER_BITS-1:0] number);
    logic [BDA_NUMBER_BITS-1:0] rest;
    digit_item_t                digits[$];
    digit_item_t                item;
    begin
      rest = number;
      do begin
        item.digit_char = ASCII_ZERO + 6'(rest % RADIX);
        item.last       = (digits.size() == 0);
        digits.push_front(item);
        rest = rest / RADIX;
      end while (rest != 0);
      foreach (digits[i]) digit_queue.push_back(digits[i]);
    end
  endtask

  always @(posedge clk) begin
    digit_item_t want;
    logic        bad;
    if (rst_n) begin
      if (out_valid) begin
        if (digit_queue.size() == 0) begin
          $display("%0t: unexpected digit, expected none, actual char %0d last %0b",
                   $time, out_digit_char, out_last);
          errors++;
        end else begin
          want = digit_queue.pop_front();
          bad  = 1'b0;
          if (out_digit_char !== want.digit_char) begin
            $display("%0t: digit_char mismatch, expected %0d, actual %0d",
                     $time, want.digit_char, out_digit_char);
            bad = 1'b1;
          end
          if (out_last !== want.last) begin
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, want.last, out_last);
            bad = 1'b1;
          end
          if (bad) errors++;
        end
      end
      if (start && !busy) queue_decimal_digits(in_number);
    end
  end

endmodule

### test/binary_to_decimal_ascii_test.sv
// Testbench top for the binary to decimal ASCII converter: drives numbers in
// bursts, runs the watchdog and gives the verdict.
// Depends on bda_pkg, binary_to_decimal_ascii and binary_to_decimal_ascii_check.
module binary_to_decimal_ascii_test;
  import bda_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                         IDLE_LIMIT   = 2000;
  localparam int                         DRAIN_CYCLES = 60;
  localparam int                         RANDOM_ITEMS = 200;
  localparam logic [BDA_NUMBER_BITS-1:0] MAX_NUMBER   = '1;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       start     = 1'b0;
  logic [BDA_NUMBER_BITS-1:0] in_number = '0;
  logic                       busy;
  logic                       out_valid;
  logic [5:0]                 out_digit_char;
  logic                       out_last;
  int                         mismatch_count;
  int                         digits_pending;
  int                         idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  binary_to_decimal_ascii dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_number     (in_number),
    .out_valid     (out_valid),
    .out_digit_char(out_digit_char),
    .out_last      (out_last)
  );

  binary_to_decimal_ascii_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_number     (in_number),
    .out_valid     (out_valid),
    .out_digit_char(out_digit_char),
    .out_last      (out_last),
    .mismatch_count(mismatch_count),
    .digits_pending(digits_pending)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("%0t: timeout, nothing accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic longint unsigned power_of_ten(input int exponent);
    longint unsigned value;
    begin
      value = 1;
      repeat (exponent) value = value * 10;
      return value;
    end
  endfunction

  // leave start high so a following item goes out back to back
  task automatic send_number(input logic [BDA_NUMBER_BITS-1:0] number);
    start     <= 1'b1;
    in_number <= number;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic wait_all_digits();
    start <= 1'b0;
    @(negedge clk);
    while (digits_pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [BDA_NUMBER_BITS-1:0] directed[] = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd101, 32'd1000,
      32'd100000, 32'd90, 32'd505, 32'd999999999, 32'd1000000000,
      32'd1234567890, 32'd2147483647, 32'd2147483648, 32'd3000000000,
      32'd4000000000, 32'd4294967294, 32'd4294967295, 32'hAAAAAAAA,
      32'h55555555, 32'd7
    };
    logic [BDA_NUMBER_BITS-1:0] number;
    longint unsigned            floor_v;
    longint unsigned            ceil_v;
    longint unsigned            scaled;
    int                         digits;
    int                         burst_len;
    int                         sent;
    bit                         paused;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      send_number(directed[i]);
      if (i % 6 == 5) hold_off($urandom_range(1, 8));
    end
    wait_all_digits();

    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      burst_len = $urandom_range(1, 12);
      repeat (burst_len) begin
        case ($urandom_range(0, 3))
          0: begin
            number = $urandom;
          end
          1: begin
            digits  = $urandom_range(1, 10);
            floor_v = (digits == 1) ? 0 : power_of_ten(digits - 1);
            ceil_v  = power_of_ten(digits) - 1;
            if (ceil_v > MAX_NUMBER) ceil_v = MAX_NUMBER;
            number = $urandom_range(32'(ceil_v), 32'(floor_v));
          end
          2: begin
            scaled = power_of_ten($urandom_range(0, 9)) * $urandom_range(1, 9);
            if (scaled > MAX_NUMBER) scaled = power_of_ten(9);
            number = 32'(scaled);
          end
          default: begin
            number = $urandom_range(0, 20);
          end
        endcase
        send_number(number);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) hold_off($urandom_range(1, 30));
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        wait_all_digits();
        paused = 1'b1;
      end
    end

    wait_all_digits();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (digits_pending != 0) begin
      $display("%0t: %0d expected digits never arrived", $time, digits_pending);
    end
    if (mismatch_count == 0 && digits_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/bda_pkg.sv
rtl/bda_queue.sv
rtl/bda_conv.sv
rtl/binary_to_decimal_ascii.sv
test/binary_to_decimal_ascii_check.sv
test/binary_to_decimal_ascii_test.sv
